// File: src/aes_pkg.sv
package aes_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned Rounds   = 10;
  localparam int unsigned CfgIdxW  = 1;

  // wait count loaded on reset or a key write; busy holds until the last round key has settled
  localparam int unsigned KeySettle = Rounds + 1;
  localparam int unsigned KeyCntW   = 4;

  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b1;

  typedef logic [127:0] blk_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] Rcon [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(blk_t b, int i);
    get_byte = b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t sub_shift(blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = Sbox[get_byte(s, 4*((c+r)%4)+r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_cols(blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  // one step of the key expansion: round key n-1 to round key n
  function automatic blk_t next_key(blk_t k, logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = k[31:0];
    t  = {Sbox[t[23:16]], Sbox[t[15:8]], Sbox[t[7:0]], Sbox[t[31:24]]} ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

// File: src/aes_keys.sv
module aes_keys (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [aes_pkg::CfgIdxW-1:0] wr_idx_i,
  input  logic [aes_pkg::KeyW-1:0] wr_data_i,
  output aes_pkg::blk_t            rkey_o [11],
  output logic                     busy_o
);
  import aes_pkg::*;

  logic [KeyW-1:0] key_hi_q, key_lo_q;
  blk_t            rk_q [11];
  blk_t            rk_d [11];
  logic [KeyCntW-1:0] wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CfgKeyHigh: key_hi_q <= wr_data_i;
        CfgKeyLow:  key_lo_q <= wr_data_i;
        default:    ;
      endcase
    end
  end

  // expansion ripples one round per cycle through the registered round keys after a write
  always_comb begin
    rk_d[0] = {key_hi_q, key_lo_q};
    for (int n = 1; n < 11; n++) begin
      rk_d[n] = next_key(rk_q[n-1], Rcon[n-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < 11; n++) rk_q[n] <= rk_d[n];
  end

  // busy while the schedule ripples after reset or a write
  always_comb begin
    wait_d = wait_q;
    if (wr_en_i) wait_d = KeyCntW'(KeySettle);
    else if (wait_q != '0) wait_d = wait_q - KeyCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wait_q <= KeyCntW'(KeySettle);
    else wait_q <= wait_d;
  end

  assign rkey_o = rk_q;
  assign busy_o = (wait_q != '0);
endmodule

// File: src/aes_round.sv
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  aes_pkg::blk_t state_i,
  input  aes_pkg::blk_t rkey_i,
  input  aes_pkg::blk_t fkey_i,
  output logic          valid_o,
  output aes_pkg::blk_t state_o
);
  import aes_pkg::*;

  logic valid_q;
  blk_t state_q, state_d, ss;

  always_comb begin
    ss = sub_shift(state_i ^ rkey_i);
    state_d = LastRound ? (ss ^ fkey_i) : mix_cols(ss);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
endmodule

// File: src/aes128_block_encrypt.sv
// aes-128 encryption, electronic codebook, one round per pipeline stage
// - input channel: plain_high_i/plain_low_i with in_valid_i/in_ready_o, a word
//   is taken when both are high
// - output channel: cipher_high_o/cipher_low_o with out_valid_o/out_ready_i
// - key: cfg_we_i writes cfg_idx_i 0 (key bytes 0..7) or 1 (bytes 8..15);
//   other indexes are ignored
// - a word passes the ten round stages in order, each holding one sbox layer
//   and, in all but the last, one mixcolumns layer; throughput one word per
//   cycle while no output stall or key settling holds the pipeline
// - the round keys are expanded one round per cycle after a key write;
//   in_ready_o stays low after a write or reset while the schedule settles;
//   the user must write keys only while the pipeline is empty (not enforced)
// - reset clears all valid bits and loads the all-zero key
// - when the receiver stalls, stages hold and in_ready_o drops only if the last
//   stage holds a word not being taken; in_ready_o also drops while keys settle
module aes128_block_encrypt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [aes_pkg::HalfW-1:0]   plain_high_i,
  input  logic [aes_pkg::HalfW-1:0]   plain_low_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [aes_pkg::HalfW-1:0]   cipher_high_o,
  output logic [aes_pkg::HalfW-1:0]   cipher_low_o,
  input  logic                        cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [aes_pkg::KeyW-1:0]    cfg_data_i
);
  import aes_pkg::*;

  blk_t rkey [11];
  logic valid [11];
  blk_t state [11];
  logic adv;
  logic keys_busy;

  aes_keys u_keys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_we_i),
    .wr_idx_i  (cfg_idx_i),
    .wr_data_i (cfg_data_i),
    .rkey_o    (rkey),
    .busy_o    (keys_busy)
  );

  // whole pipeline advances together unless the output word is stuck
  assign adv        = !valid[Rounds] || out_ready_i;
  assign in_ready_o = adv && !keys_busy;

  // no word enters while the key schedule is settling
  assign valid[0] = in_valid_i && !keys_busy;
  assign state[0] = {plain_high_i, plain_low_i};

  for (genvar r = 0; r < Rounds; r++) begin : g_rnd
    aes_round #(.LastRound(r == Rounds - 1)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (valid[r]),
      .state_i (state[r]),
      .rkey_i  (rkey[r]),
      .fkey_i  (rkey[Rounds]),
      .valid_o (valid[r+1]),
      .state_o (state[r+1])
    );
  end

  assign out_valid_o   = valid[Rounds];
  assign cipher_high_o = state[Rounds][127:64];
  assign cipher_low_o  = state[Rounds][63:0];
endmodule
